FILE: rtl/epcc_pkg.sv
// Package for the Ethernet port control register block.
// Holds the request, command and state codes, the register bit masks and
// the word types that pass between the block's modules. No dependencies.
package epcc_pkg;

  // Bus request codes
  typedef enum logic [2:0] {
    REQ_READ     = 3'd0,
    REQ_WRITE    = 3'd1,
    REQ_WRITE_B  = 3'd2,
    REQ_INT_ACK  = 3'd3,
    REQ_STS_POST = 3'd4
  } req_e;

  // Register select (offset bits 2:1)
  typedef enum logic [1:0] {
    SEL_PCSR0 = 2'd0,
    SEL_PCSR1 = 2'd1,
    SEL_PCSR2 = 2'd2,
    SEL_PCSR3 = 2'd3
  } reg_sel_e;

  // Port commands held in PCSR0 bits 3:0
  typedef enum logic [3:0] {
    CMD_NOP        = 4'd0,
    CMD_LOAD_PCB   = 4'd1,
    CMD_GET_CMD    = 4'd2,
    CMD_SELF_TEST  = 4'd3,
    CMD_RUN        = 4'd4,
    CMD_ENTER_BOOT = 4'd5,
    CMD_POLL       = 4'd8,
    CMD_ENTER_HALT = 4'd14,
    CMD_END_RUN    = 4'd15
  } cmd_e;

  // Port state
  typedef enum logic [3:0] {
    PST_READY   = 4'd2,
    PST_RUNNING = 4'd3,
    PST_HALT    = 4'd8
  } port_state_e;

  // Strobe to the DMA engine
  typedef enum logic [1:0] {
    DMA_NONE    = 2'd0,
    DMA_POLL    = 2'd1,
    DMA_GET_CMD = 2'd2
  } dma_cmd_e;

  // Register masks
  localparam logic [15:0] AddrEvenMask    = 16'o177776;
  localparam logic [15:0] HighByteMask    = 16'hFF00;
  localparam logic [15:0] ByteShiftedMask = 16'o177400;
  localparam logic [15:0] CmdMask         = 16'o000017;
  localparam logic [1:0]  HighAddrMask    = 2'b11;
  localparam logic [15:0] RsetMask        = 16'o000040;
  localparam logic [15:0] IntrMask        = 16'o000200;
  localparam logic [15:0] InteMask        = 16'o000100;
  localparam logic [15:0] UsciMask        = 16'o000400;
  localparam logic [15:0] FatlMask        = 16'o001000;
  localparam logic [15:0] DniMask         = 16'o004000;
  localparam logic [15:0] PceiMask        = 16'o040000;

  // One bus request word
  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  reg_offset;
    logic [15:0] write_data;
  } item_t;

  // One result word
  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_request;
    logic        irq_taken;
    logic [1:0]  dma_command;
    logic [17:0] pcb_base;
  } result_t;

endpackage

FILE: rtl/epcc_in_reg.sv
// Input register of the port control register block.
// Captures one request word and holds it until the register logic takes it.
// Depends on epcc_pkg.
module epcc_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  epcc_pkg::item_t item_i,
  input  logic            advance_i,
  output logic            item_valid_o,
  output epcc_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  epcc_pkg::item_t item_q;
  logic            accept;

  // Stall only while a held word cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: rtl/epcc_csr.sv
// Port registers, port state, PCB base and interrupt latch, with the
// next-state logic for one request word. Depends on epcc_pkg.
module epcc_csr (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              fire_i,
  input  epcc_pkg::item_t   item_i,
  output epcc_pkg::result_t result_o
);

  typedef struct packed {
    logic [15:0]           status;
    epcc_pkg::port_state_e port_state;
    logic [15:0]           base_lo;
    logic [1:0]            base_hi;
    logic [17:0]           pcb;
    logic                  latch;
  } csr_st_t;

  typedef struct packed {
    csr_st_t            st;
    epcc_pkg::dma_cmd_e strobe;
  } wr_t;

  // State after a port reset
  function automatic csr_st_t reset_state();
    csr_st_t s;
    s.status     = epcc_pkg::DniMask;
    s.port_state = epcc_pkg::PST_READY;
    s.base_lo    = '0;
    s.base_hi    = '0;
    s.pcb        = '0;
    s.latch      = 1'b0;
    return s;
  endfunction

  // INTR mirrors any high status bit; latch = INTE and that
  function automatic csr_st_t refresh(csr_st_t s);
    logic any;
    any = |(s.status & epcc_pkg::HighByteMask);
    if (any) begin
      s.status = s.status | epcc_pkg::IntrMask;
    end else begin
      s.status = s.status & ~epcc_pkg::IntrMask;
    end
    s.latch = (|(s.status & epcc_pkg::InteMask)) && any;
    return s;
  endfunction

  function automatic logic [15:0] reg_read(csr_st_t s, epcc_pkg::reg_sel_e sel);
    logic [15:0] w;
    case (sel)
      epcc_pkg::SEL_PCSR0: w = s.status;
      epcc_pkg::SEL_PCSR1: w = {12'd0, s.port_state};
      epcc_pkg::SEL_PCSR2: w = s.base_lo;
      epcc_pkg::SEL_PCSR3: w = {14'd0, s.base_hi};
      default:             w = '0;
    endcase
    return w;
  endfunction

  // PCSR0 write: clear-on-one, port reset, enable toggle, else command
  function automatic wr_t write_csr0(csr_st_t s, logic [15:0] d);
    wr_t         r;
    logic [15:0] set;
    r.strobe = epcc_pkg::DMA_NONE;
    set      = '0;
    s.status = s.status & ~(d & epcc_pkg::HighByteMask);
    if (|(d & epcc_pkg::RsetMask)) begin
      s = refresh(reset_state());
    end else if (|((s.status ^ d) & epcc_pkg::InteMask)) begin
      s.status = (s.status ^ epcc_pkg::InteMask) | epcc_pkg::DniMask;
      s = refresh(s);
    end else begin
      s.status = (s.status & ~epcc_pkg::CmdMask) | (d & epcc_pkg::CmdMask);
      case (epcc_pkg::cmd_e'(s.status[3:0]))
        epcc_pkg::CMD_POLL: begin
          r.strobe = epcc_pkg::DMA_POLL;
          set      = epcc_pkg::DniMask;
        end
        epcc_pkg::CMD_GET_CMD: begin
          r.strobe = epcc_pkg::DMA_GET_CMD;
          set      = epcc_pkg::DniMask;
        end
        epcc_pkg::CMD_LOAD_PCB: begin
          s.pcb = {s.base_hi & epcc_pkg::HighAddrMask, s.base_lo & epcc_pkg::AddrEvenMask};
          set   = epcc_pkg::DniMask;
        end
        epcc_pkg::CMD_SELF_TEST: begin
          set          = epcc_pkg::DniMask;
          s.status     = s.status & ~(epcc_pkg::UsciMask | epcc_pkg::FatlMask);
          s.port_state = epcc_pkg::PST_READY;
        end
        epcc_pkg::CMD_RUN: begin
          if (s.port_state == epcc_pkg::PST_READY) begin
            s.port_state = epcc_pkg::PST_RUNNING;
            set          = epcc_pkg::DniMask;
          end else begin
            set = epcc_pkg::PceiMask;
          end
        end
        epcc_pkg::CMD_ENTER_HALT: begin
          if (s.port_state == epcc_pkg::PST_READY ||
              s.port_state == epcc_pkg::PST_RUNNING) begin
            s.port_state = epcc_pkg::PST_HALT;
            set          = epcc_pkg::DniMask;
          end else begin
            set = epcc_pkg::PceiMask;
          end
        end
        epcc_pkg::CMD_END_RUN: begin
          if (s.port_state == epcc_pkg::PST_RUNNING) begin
            s.port_state = epcc_pkg::PST_READY;
            set          = epcc_pkg::DniMask;
          end else begin
            set = epcc_pkg::PceiMask;
          end
        end
        epcc_pkg::CMD_ENTER_BOOT: set = epcc_pkg::PceiMask;
        epcc_pkg::CMD_NOP:        set = '0;
        default:                  set = epcc_pkg::DniMask;
      endcase
      s.status = s.status | set;
      s = refresh(s);
    end
    r.st = s;
    return r;
  endfunction

  function automatic wr_t reg_write(csr_st_t s, epcc_pkg::reg_sel_e sel,
                                    logic [15:0] w);
    wr_t r;
    r.st     = s;
    r.strobe = epcc_pkg::DMA_NONE;
    case (sel)
      epcc_pkg::SEL_PCSR0: r = write_csr0(s, w);
      epcc_pkg::SEL_PCSR1: r.st = s;
      epcc_pkg::SEL_PCSR2: r.st.base_lo = w & epcc_pkg::AddrEvenMask;
      epcc_pkg::SEL_PCSR3: r.st.base_hi = w[1:0] & epcc_pkg::HighAddrMask;
      default:             r.st = s;
    endcase
    return r;
  endfunction

  csr_st_t            st_q, st_d;
  logic               en_q;
  epcc_pkg::reg_sel_e sel;
  logic               lane_hi;
  logic [7:0]         b;
  logic [15:0]        merged;
  wr_t                wr;

  assign sel     = epcc_pkg::reg_sel_e'(item_i.reg_offset[2:1]);
  assign lane_hi = item_i.reg_offset[0];
  assign b       = item_i.write_data[7:0];

  // Next state and result for the held request word
  always_comb begin
    st_d     = st_q;
    merged   = reg_read(st_q, sel);
    wr.st    = st_q;
    wr.strobe = epcc_pkg::DMA_NONE;
    result_o = '0;
    case (epcc_pkg::req_e'(item_i.req_type))
      epcc_pkg::REQ_READ: begin
        if (en_q) begin
          result_o.read_data = reg_read(st_q, sel);
        end
      end
      epcc_pkg::REQ_WRITE: begin
        if (en_q) begin
          wr   = reg_write(st_q, sel, item_i.write_data);
          st_d = wr.st;
        end
      end
      epcc_pkg::REQ_WRITE_B: begin
        if (en_q) begin
          if (sel == epcc_pkg::SEL_PCSR0) begin
            if (lane_hi) begin
              st_d.status = st_q.status & ~({b, 8'd0} & epcc_pkg::ByteShiftedMask);
              st_d = refresh(st_d);
            end else begin
              wr   = write_csr0(st_q, {8'd0, b});
              st_d = wr.st;
            end
          end else begin
            if (lane_hi) begin
              merged = {b, merged[7:0]};
            end else begin
              merged = {merged[15:8], b};
            end
            wr   = reg_write(st_q, sel, merged);
            st_d = wr.st;
          end
        end
      end
      epcc_pkg::REQ_INT_ACK: begin
        if (en_q) begin
          st_d = refresh(st_q);
          if (st_d.latch) begin
            st_d.latch         = 1'b0;
            result_o.irq_taken = 1'b1;
          end
        end
      end
      epcc_pkg::REQ_STS_POST: begin
        st_d.status = st_q.status | (item_i.write_data & epcc_pkg::ByteShiftedMask);
        st_d = refresh(st_d);
      end
      default: st_d = st_q;
    endcase
    result_o.dma_command = wr.strobe;
    result_o.irq_request = st_d.latch;
    result_o.pcb_base    = st_d.pcb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= reset_state();
      en_q <= 1'b0;
    end else begin
      if (fire_i) begin
        st_q <= st_d;
      end
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
    end
  end

endmodule

FILE: rtl/ethernet_port_csr_controller_core.sv
// Top level of the Ethernet port control register block.
// Instantiates epcc_in_reg and epcc_csr and holds the result register.
// Depends on epcc_pkg.
//
// Usage:
//   Request channel: in_valid_i / in_stall_o carry one bus request word
//   (req_type_i, reg_offset_i, write_data_i), taken at an edge with valid
//   high and stall low. Result channel: out_valid_o / out_stall_i carry one
//   result word per request (read_data_o, irq_request_o, irq_taken_o,
//   dma_command_o, pcb_base_o). dma_command_o is a one-word strobe.
//   Configuration: cfg_we_i writes cfg_wdata_i into the device enable bit;
//   write it only while no request is in flight.
//   A word taken into the input register is decoded there by the register
//   logic, and its result word is then captured in the result register.
//   Throughput is one word per cycle while out_stall_i stays low; the
//   register logic between the two register stages is single-pass.
//   Reset puts the port in the ready state with only the done bit set, clears
//   the PCB base, the interrupt latch and the device enable, and empties
//   both register stages. While the receiver stalls the result word holds;
//   one more request is taken into the input register, then in_stall_o rises.
module ethernet_port_csr_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [2:0]  reg_offset_i,
  input  logic [15:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic        irq_request_o,
  output logic        irq_taken_o,
  output logic [1:0]  dma_command_o,
  output logic [17:0] pcb_base_o
);

  epcc_pkg::item_t   in_item;
  epcc_pkg::item_t   held_item;
  epcc_pkg::result_t result;
  epcc_pkg::result_t res_q;
  logic              held_valid;
  logic              advance;
  logic              out_valid_q, out_valid_d;

  assign in_item.req_type   = req_type_i;
  assign in_item.reg_offset = reg_offset_i;
  assign in_item.write_data = write_data_i;

  // Held word moves on when the result register is free or being emptied
  assign advance = held_valid && (!out_valid_q || !out_stall_i);

  epcc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (in_item),
    .advance_i    (advance),
    .item_valid_o (held_valid),
    .item_o       (held_item)
  );

  epcc_csr u_csr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (advance),
    .item_i      (held_item),
    .result_o    (result)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = res_q.read_data;
  assign irq_request_o = res_q.irq_request;
  assign irq_taken_o   = res_q.irq_taken;
  assign dma_command_o = res_q.dma_command;
  assign pcb_base_o    = res_q.pcb_base;

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for the Ethernet port control register block.
// Drives bus request words, predicts each result word, checks them in order.
// Depends on epcc_pkg and ethernet_port_csr_controller_core.
module tb_top;

  localparam logic [2:0] ReqUndefLo = 3'd5;
  localparam logic [2:0] ReqUndefHi = 3'd7;
  localparam int unsigned LongHold = 80;

  typedef enum {ROW_CFG, ROW_PRED, ROW_TYPED} row_kind_e;

  // One row of the directed table; rd/irq/pcb only matter for typed rows
  typedef struct {
    row_kind_e   kind;
    logic [2:0]  req;
    logic [2:0]  off;
    logic [15:0] data;
    logic [15:0] rd;
    logic        irq;
    logic [17:0] pcb;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  req_type_i = epcc_pkg::REQ_READ;
  logic [2:0]  reg_offset_i = 3'd0;
  logic [15:0] write_data_i = 16'h0000;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] read_data_o;
  logic        irq_request_o;
  logic        irq_taken_o;
  logic [1:0]  dma_command_o;
  logic [17:0] pcb_base_o;

  ethernet_port_csr_controller_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .reg_offset_i,
    .write_data_i,
    .out_valid_o,
    .out_stall_i,
    .read_data_o,
    .irq_request_o,
    .irq_taken_o,
    .dma_command_o,
    .pcb_base_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Shadow copy of the port registers
  logic [15:0]           csr0_q;
  epcc_pkg::port_state_e pstate_q;
  logic [15:0]           base_lo_q;
  logic [1:0]            base_hi_q;
  logic [17:0]           pcb_q;
  logic                  irq_latch_q;
  logic                  dev_en_q;

  epcc_pkg::result_t pending_results[$];
  int unsigned  mismatches = 0;
  int unsigned  words_sent = 0;
  int unsigned  words_checked = 0;
  int unsigned  strobes_seen = 0;
  int unsigned  acks_taken = 0;
  int unsigned  req_stall_cycles = 0;
  int unsigned  settings_used = 0;
  int unsigned  tx_max_gap = 10;
  int unsigned  rx_max_hold = 10;
  bit           long_hold_done = 1'b0;

  epcc_pkg::cmd_e cmd_list [0:8] = '{
    epcc_pkg::CMD_NOP, epcc_pkg::CMD_LOAD_PCB, epcc_pkg::CMD_GET_CMD,
    epcc_pkg::CMD_SELF_TEST, epcc_pkg::CMD_RUN, epcc_pkg::CMD_ENTER_BOOT,
    epcc_pkg::CMD_POLL, epcc_pkg::CMD_ENTER_HALT, epcc_pkg::CMD_END_RUN
  };

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // INTR mirrors any high-byte status bit; the latch needs INTE as well
  function automatic void irq_refresh();
    logic any;
    any = |(csr0_q & epcc_pkg::HighByteMask);
    csr0_q = any ? (csr0_q | epcc_pkg::IntrMask) : (csr0_q & ~epcc_pkg::IntrMask);
    irq_latch_q = any && ((csr0_q & epcc_pkg::InteMask) != 16'h0000);
  endfunction

  function automatic void port_clear();
    csr0_q      = epcc_pkg::DniMask;
    pstate_q    = epcc_pkg::PST_READY;
    base_lo_q   = 16'h0000;
    base_hi_q   = 2'b00;
    pcb_q       = 18'h00000;
    irq_latch_q = 1'b0;
  endfunction

  function automatic logic [15:0] csr_word(epcc_pkg::reg_sel_e sel);
    case (sel)
      epcc_pkg::SEL_PCSR0: return csr0_q;
      epcc_pkg::SEL_PCSR1: return {12'h000, pstate_q};
      epcc_pkg::SEL_PCSR2: return base_lo_q;
      default:             return {14'h0000, base_hi_q};
    endcase
  endfunction

  // PCSR0 write: clear-on-one status, reset, enable toggle, else the command
  function automatic epcc_pkg::dma_cmd_e csr0_store(logic [15:0] data);
    logic [15:0]        raise;
    epcc_pkg::dma_cmd_e strobe;
    raise  = 16'h0000;
    strobe = epcc_pkg::DMA_NONE;
    csr0_q &= ~(data & epcc_pkg::HighByteMask);
    if ((data & epcc_pkg::RsetMask) != 16'h0000) begin
      port_clear();
      irq_refresh();
      return epcc_pkg::DMA_NONE;
    end
    if (((csr0_q ^ data) & epcc_pkg::InteMask) != 16'h0000) begin
      csr0_q = (csr0_q ^ epcc_pkg::InteMask) | epcc_pkg::DniMask;
      irq_refresh();
      return epcc_pkg::DMA_NONE;
    end
    csr0_q = (csr0_q & ~epcc_pkg::CmdMask) | (data & epcc_pkg::CmdMask);
    case (csr0_q[3:0])
      epcc_pkg::CMD_POLL: begin
        strobe = epcc_pkg::DMA_POLL;
        raise  = epcc_pkg::DniMask;
      end
      epcc_pkg::CMD_GET_CMD: begin
        strobe = epcc_pkg::DMA_GET_CMD;
        raise  = epcc_pkg::DniMask;
      end
      epcc_pkg::CMD_LOAD_PCB: begin
        pcb_q = {base_hi_q & epcc_pkg::HighAddrMask, base_lo_q & epcc_pkg::AddrEvenMask};
        raise = epcc_pkg::DniMask;
      end
      epcc_pkg::CMD_SELF_TEST: begin
        raise    = epcc_pkg::DniMask;
        csr0_q  &= ~(epcc_pkg::UsciMask | epcc_pkg::FatlMask);
        pstate_q = epcc_pkg::PST_READY;
      end
      epcc_pkg::CMD_RUN: begin
        if (pstate_q == epcc_pkg::PST_READY) begin
          pstate_q = epcc_pkg::PST_RUNNING;
          raise    = epcc_pkg::DniMask;
        end else begin
          raise = epcc_pkg::PceiMask;
        end
      end
      epcc_pkg::CMD_ENTER_HALT: begin
        if (pstate_q == epcc_pkg::PST_READY || pstate_q == epcc_pkg::PST_RUNNING) begin
          pstate_q = epcc_pkg::PST_HALT;
          raise    = epcc_pkg::DniMask;
        end else begin
          raise = epcc_pkg::PceiMask;
        end
      end
      epcc_pkg::CMD_END_RUN: begin
        if (pstate_q == epcc_pkg::PST_RUNNING) begin
          pstate_q = epcc_pkg::PST_READY;
          raise    = epcc_pkg::DniMask;
        end else begin
          raise = epcc_pkg::PceiMask;
        end
      end
      epcc_pkg::CMD_ENTER_BOOT: raise = epcc_pkg::PceiMask;
      epcc_pkg::CMD_NOP: ;
      default: raise = epcc_pkg::DniMask;
    endcase
    csr0_q |= raise;
    irq_refresh();
    return strobe;
  endfunction

  function automatic epcc_pkg::dma_cmd_e csr_store(epcc_pkg::reg_sel_e sel,
                                                   logic [15:0] data);
    case (sel)
      epcc_pkg::SEL_PCSR0: return csr0_store(data);
      epcc_pkg::SEL_PCSR2: base_lo_q = data & epcc_pkg::AddrEvenMask;
      epcc_pkg::SEL_PCSR3: base_hi_q = data[1:0] & epcc_pkg::HighAddrMask;
      default: ;
    endcase
    return epcc_pkg::DMA_NONE;
  endfunction

  // Result word for one accepted request; advances the shadow state
  function automatic epcc_pkg::result_t predict_access(epcc_pkg::item_t w);
    epcc_pkg::reg_sel_e sel;
    epcc_pkg::result_t  r;
    logic [15:0]        merged;
    sel = epcc_pkg::reg_sel_e'(w.reg_offset[2:1]);
    r   = '0;
    case (w.req_type)
      epcc_pkg::REQ_READ: if (dev_en_q) r.read_data = csr_word(sel);
      epcc_pkg::REQ_WRITE: if (dev_en_q) r.dma_command = csr_store(sel, w.write_data);
      epcc_pkg::REQ_WRITE_B: begin
        if (dev_en_q) begin
          if (sel == epcc_pkg::SEL_PCSR0 && w.reg_offset[0]) begin
            // high lane of PCSR0 only clears status bits
            csr0_q &= ~({w.write_data[7:0], 8'h00} & epcc_pkg::ByteShiftedMask);
            irq_refresh();
          end else if (sel == epcc_pkg::SEL_PCSR0) begin
            r.dma_command = csr0_store({8'h00, w.write_data[7:0]});
          end else begin
            merged = csr_word(sel);
            if (w.reg_offset[0]) merged[15:8] = w.write_data[7:0];
            else merged[7:0] = w.write_data[7:0];
            r.dma_command = csr_store(sel, merged);
          end
        end
      end
      epcc_pkg::REQ_INT_ACK: begin
        if (dev_en_q) begin
          irq_refresh();
          if (irq_latch_q) begin
            irq_latch_q = 1'b0;
            r.irq_taken = 1'b1;
          end
        end
      end
      epcc_pkg::REQ_STS_POST: begin
        // engine posts work whatever the enable
        csr0_q |= w.write_data & epcc_pkg::ByteShiftedMask;
        irq_refresh();
      end
      default: ;
    endcase
    r.irq_request = irq_latch_q;
    r.pcb_base    = pcb_q;
    return r;
  endfunction

  // Random request word; PCSR0 command words mostly keep INTE and skip reset
  function automatic epcc_pkg::item_t random_access();
    epcc_pkg::item_t w;
    int unsigned     pick;
    logic [3:0]      cmd;
    pick         = $urandom_range(0, 99);
    w.req_type   = epcc_pkg::REQ_WRITE;
    w.reg_offset = 3'($urandom_range(0, 7));
    w.write_data = 16'($urandom);
    if (pick < 20) begin
      w.req_type = epcc_pkg::REQ_READ;
    end else if (pick < 50) begin
      w.reg_offset = {epcc_pkg::SEL_PCSR0, 1'($urandom_range(0, 1))};
      cmd = ($urandom_range(0, 3) == 0) ? 4'($urandom) : cmd_list[$urandom_range(0, 8)];
      if ($urandom_range(0, 3) != 0) w.write_data &= ~epcc_pkg::HighByteMask;
      w.write_data = (w.write_data &
                      ~(epcc_pkg::InteMask | epcc_pkg::RsetMask | epcc_pkg::CmdMask)) |
                     (csr0_q & epcc_pkg::InteMask) | {12'h000, cmd};
      if ($urandom_range(0, 9) == 0) w.write_data ^= epcc_pkg::InteMask;
      if ($urandom_range(0, 24) == 0) w.write_data |= epcc_pkg::RsetMask;
    end else if (pick < 60) begin
      w.req_type = epcc_pkg::REQ_WRITE;
    end else if (pick < 72) begin
      w.req_type = epcc_pkg::REQ_WRITE_B;
    end else if (pick < 82) begin
      w.req_type = epcc_pkg::REQ_INT_ACK;
    end else if (pick < 95) begin
      w.req_type = epcc_pkg::REQ_STS_POST;
      if ($urandom_range(0, 1) == 0) w.write_data = 16'h0001 << $urandom_range(8, 15);
    end else begin
      w.req_type = 3'($urandom_range(ReqUndefLo, ReqUndefHi));
    end
    return w;
  endfunction

  // Offer one word, hold it until taken, then idle for a random gap
  task automatic send_word(epcc_pkg::item_t w, bit typed, epcc_pkg::result_t typed_want);
    epcc_pkg::result_t predicted;
    int unsigned       gap;
    in_valid_i   <= 1'b1;
    req_type_i   <= w.req_type;
    reg_offset_i <= w.reg_offset;
    write_data_i <= w.write_data;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_access(w);
    pending_results.push_back(typed ? typed_want : predicted);
    words_sent++;
    if (predicted.dma_command != epcc_pkg::DMA_NONE) strobes_seen++;
    if (predicted.irq_taken) acks_taken++;
    gap = $urandom_range(0, tx_max_gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_device_enable(bit en);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    dev_en_q     = en;
    settings_used++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random stall per word, one long hold to back the block up
  initial begin : rx_pacing
    int unsigned hold;
    forever begin
      if (!long_hold_done && words_checked >= 600) begin
        hold = LongHold;
        long_hold_done = 1'b1;
      end else begin
        hold = $urandom_range(0, rx_max_hold);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Compare each taken result word with the oldest prediction
  always @(posedge clk_i) begin : result_check
    epcc_pkg::result_t want;
    if (in_valid_i && in_stall_o) req_stall_cycles++;
    if (out_valid_o && !out_stall_i) begin
      words_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing pending", 32'(read_data_o), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (read_data_o !== want.read_data)
          report_mismatch("read_data", 32'(read_data_o), 32'(want.read_data));
        if (irq_request_o !== want.irq_request)
          report_mismatch("irq_request", 32'(irq_request_o), 32'(want.irq_request));
        if (irq_taken_o !== want.irq_taken)
          report_mismatch("irq_taken", 32'(irq_taken_o), 32'(want.irq_taken));
        if (dma_command_o !== want.dma_command)
          report_mismatch("dma_command", 32'(dma_command_o), 32'(want.dma_command));
        if (pcb_base_o !== want.pcb_base)
          report_mismatch("pcb_base", 32'(pcb_base_o), 32'(want.pcb_base));
      end
    end
  end

  // Directed table: disabled accesses, reset bit, base load, every command but NOP
  step_t dir_steps [0:29] = '{
    '{ROW_CFG,   epcc_pkg::REQ_READ,     3'd0, 16'h0000, 16'h0000, 1'b0, 18'h00000},
    '{ROW_TYPED, epcc_pkg::REQ_READ,     3'd0, 16'h0000, 16'h0000, 1'b0, 18'h00000},
    '{ROW_TYPED, epcc_pkg::REQ_WRITE,    3'd0, 16'h0021, 16'h0000, 1'b0, 18'h00000},
    '{ROW_TYPED, epcc_pkg::REQ_STS_POST, 3'd0, 16'hFF00, 16'h0000, 1'b0, 18'h00000},
    '{ROW_CFG,   epcc_pkg::REQ_READ,     3'd0, 16'h0001, 16'h0000, 1'b0, 18'h00000},
    '{ROW_TYPED, epcc_pkg::REQ_READ,     3'd0, 16'h0000, 16'hFF80, 1'b0, 18'h00000},
    '{ROW_TYPED, epcc_pkg::REQ_READ,     3'd2, 16'h0000, 16'h0002, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd0, 16'hFFFF, 16'h0000, 1'b0, 18'h00000},
    '{ROW_TYPED, epcc_pkg::REQ_READ,     3'd0, 16'h0000, 16'h0880, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd4, 16'hFFFF, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd6, 16'hFFFF, 16'h0000, 1'b0, 18'h00000},
    '{ROW_TYPED, epcc_pkg::REQ_WRITE,    3'd0, 16'h0001, 16'h0000, 1'b0, 18'h3FFFE},
    '{ROW_TYPED, epcc_pkg::REQ_READ,     3'd5, 16'h0000, 16'hFFFE, 1'b0, 18'h3FFFE},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd0, 16'h0040, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_INT_ACK,  3'd0, 16'h0000, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd0, 16'h0042, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd0, 16'h0048, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd0, 16'h0044, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd0, 16'h004F, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd0, 16'h004F, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd0, 16'h004E, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd0, 16'h0044, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd0, 16'h0043, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd0, 16'h0045, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE,    3'd0, 16'h0047, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE_B,  3'd1, 16'h00FF, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE_B,  3'd0, 16'h0021, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE_B,  3'd5, 16'h00AB, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  epcc_pkg::REQ_WRITE_B,  3'd2, 16'h00FF, 16'h0000, 1'b0, 18'h00000},
    '{ROW_PRED,  ReqUndefHi,             3'd0, 16'hFFFF, 16'h0000, 1'b0, 18'h00000}
  };

  // Random phases: enable setting and word count; phase 3 runs without idling
  bit          phase_en  [0:5] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
  int unsigned phase_len [0:5] = '{400, 100, 400, 400, 100, 400};

  initial begin : stimulus
    epcc_pkg::item_t   w;
    epcc_pkg::result_t want;
    port_clear();
    dev_en_q = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == ROW_CFG) begin
        set_device_enable(dir_steps[i].data[0]);
      end else begin
        w    = '{req_type: dir_steps[i].req, reg_offset: dir_steps[i].off,
                 write_data: dir_steps[i].data};
        want = '{read_data: dir_steps[i].rd, irq_request: dir_steps[i].irq,
                 irq_taken: 1'b0, dma_command: epcc_pkg::DMA_NONE,
                 pcb_base: dir_steps[i].pcb};
        send_word(w, dir_steps[i].kind == ROW_TYPED, want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      set_device_enable(phase_en[p]);
      tx_max_gap  = (p == 3) ? 0 : 10;
      rx_max_hold = (p == 3) ? 0 : 10;
      repeat (phase_len[p]) send_word(random_access(), 1'b0, '0);
    end

    drain_results();
    if (pending_results.size() != 0)
      report_mismatch("words never delivered", pending_results.size(), 32'h0);
    $display("Ran %0d bus words under %0d enable settings, %0d checked.",
             words_sent, settings_used, words_checked);
    $display("%0d DMA strobes, %0d interrupts taken, %0d cycles of request back-pressure.",
             strobes_seen, acks_taken, req_stall_cycles);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
